FILE: design/msfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfd_pkg: shared types and codes of the multi-session frame deframer
// Request and result payloads, parse phase codes, kind codes and register
// indexes.
// ----------------------------------------------------------------------------
package msfd_pkg;

  // Item operation codes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  // Result kind codes
  localparam logic [1:0] KIND_OPTION = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hfe;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hef;

  // Per-session parse phase
  typedef enum logic [2:0] {
    PH_HUNT1  = 3'd0,
    PH_HUNT2  = 3'd1,
    PH_OLEN_H = 3'd2,
    PH_OLEN_L = 3'd3,
    PH_OPTION = 3'd4,
    PH_DLEN_H = 3'd5,
    PH_DLEN_L = 3'd6,
    PH_DATA   = 3'd7
  } phase_t;

  // One entry of the session state memory
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  len_high;
    logic [15:0] remaining;
  } sess_state_t;

  typedef struct packed {
    logic       op;
    logic [3:0] session;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [3:0] out_session;
    logic [1:0] kind;
    logic [7:0] payload;
    logic       frame_end;
  } result_t;

endpackage

FILE: design/multi_session_length_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_session_length_frame_deframer: per-session sync/length frame parser
// Session state lives in one synchronous memory, read at request accept and
// written back from the update stage, with forwarding of the last write.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : item_valid / item_stall / item. Each request is a received
//                    byte for a session, or a close that sends that session's
//                    parser back to hunting the first sync byte.
//   result channel : result_valid / result_stall / result. Zero or one result
//                    per request: an option byte, a data byte (frame_end on
//                    the last) or an empty frame-end marker.
//   config channel : cfg_valid / cfg_ready / cfg_index / cfg_data, always
//                    ready. Write only while the block is idle.
// Path: an accepted request reads its entry from memory into the update
//   stage, which then loads its result into the output register, where it
//   can be taken; a full, stalled output register holds the update stage.
// Throughput: one request per cycle for any session pattern, unless a result
//   waits on result_stall; the memory read/write-back pair is forwarded so
//   back-to-back requests to the same session do not wait.
// Reset: all sessions return to hunting at once (per-entry valid bits), and
//   the sync bytes go to 0xfe / 0xef. No clearing pass is needed.
// Stall: while result_stall holds a full output register, a request that
//   produces a result waits in the update stage and item_stall rises;
//   requests without a result keep flowing.
// ----------------------------------------------------------------------------
module multi_session_length_frame_deframer
  import msfd_pkg::*;
#(
  parameter int SESSIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int SIDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

  // Configuration registers
  logic [7:0] sync_first;
  logic [7:0] sync_second;

  // State memory and its valid bits
  sess_state_t               sess_mem [SESSIONS];
  logic [SESSIONS-1:0]       sess_vld;

  // Request side
  logic                      acc;
  logic [SIDX_W+3:0]         sess_wide;
  logic [SIDX_W-1:0]         rd_addr;
  logic                      rd_in_range;

  // Update stage
  logic                      s1_valid;
  item_t                     s1_item;
  logic [SIDX_W-1:0]         s1_addr;
  logic                      s1_in_range;
  logic                      s1_vld;
  sess_state_t               rdata;
  logic                      fwd_hit;
  sess_state_t               fwd_data;
  logic                      s1_adv;

  sess_state_t               cur;
  sess_state_t               state_next;
  logic                      res_en;
  result_t                   res;
  logic [15:0]               len16;
  logic                      wr_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYNC_FIRST:  sync_first  <= cfg_data;
        REG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Map the session field onto the memory address; drop sessions past depth.
  assign sess_wide   = {{SIDX_W{1'b0}}, item.session};
  assign rd_addr     = sess_wide[SIDX_W-1:0];
  assign rd_in_range = (32'(item.session) < SESSIONS);

  // Advance the update stage unless its result would land on a full,
  // stalled output register.
  assign s1_adv     = !(s1_in_range && res_en) || !result_valid || !result_stall;
  assign item_stall = s1_valid && !s1_adv;
  assign acc        = item_valid && !item_stall;
  assign wr_en      = s1_valid && s1_adv && s1_in_range;

  // Memory: read at accept, write back from the update stage.
  always_ff @(posedge clk) begin
    if (acc) begin
      rdata <= sess_mem[rd_addr];
    end
    if (wr_en) begin
      sess_mem[s1_addr] <= state_next;
    end
  end

  // Valid bits, update stage control and forwarding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sess_vld <= '0;
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (wr_en) begin
        sess_vld[s1_addr] <= 1'b1;
      end
      if (acc) begin
        s1_valid <= 1'b1;
        // Read and write of the same entry at this edge: the read sees old
        // data, so take the written word instead.
        fwd_hit  <= wr_en && (s1_addr == rd_addr);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item     <= item;
      s1_addr     <= rd_addr;
      s1_in_range <= rd_in_range;
      s1_vld      <= sess_vld[rd_addr];
      fwd_data    <= state_next;
    end
  end

  // Current entry: forwarded word, stored word, or hunting for a fresh entry.
  always_comb begin
    cur = rdata;
    if (fwd_hit) begin
      cur = fwd_data;
    end else if (!s1_vld) begin
      cur.phase = PH_HUNT1;
    end
  end

  assign len16 = {cur.len_high, s1_item.value};

  // Parse step for one request of a session: a received byte or a close.
  always_comb begin
    state_next      = cur;
    res_en          = 1'b0;
    res.out_session = s1_item.session;
    res.kind        = KIND_OPTION;
    res.payload     = s1_item.value;
    res.frame_end   = 1'b0;
    if (s1_item.op == OP_CLOSE) begin
      state_next.phase = PH_HUNT1;
    end else begin
      case (cur.phase)
        PH_HUNT1: begin
          if (s1_item.value == sync_first) begin
            state_next.phase = PH_HUNT2;
          end
        end
        PH_HUNT2: begin
          state_next.phase = (s1_item.value == sync_second) ? PH_OLEN_H : PH_HUNT1;
        end
        PH_OLEN_H: begin
          state_next.len_high = s1_item.value;
          state_next.phase    = PH_OLEN_L;
        end
        PH_OLEN_L: begin
          state_next.remaining = len16;
          state_next.phase     = (len16 != 16'd0) ? PH_OPTION : PH_DLEN_H;
        end
        PH_OPTION: begin
          res_en = 1'b1;
          if (cur.remaining <= 16'd1) begin
            state_next.remaining = 16'd0;
            state_next.phase     = PH_DLEN_H;
          end else begin
            state_next.remaining = cur.remaining - 16'd1;
          end
        end
        PH_DLEN_H: begin
          state_next.len_high = s1_item.value;
          state_next.phase    = PH_DLEN_L;
        end
        PH_DLEN_L: begin
          state_next.remaining = len16;
          if (len16 == 16'd0) begin
            state_next.phase = PH_HUNT1;
            res_en           = 1'b1;
            res.kind         = KIND_EMPTY;
            res.payload      = 8'd0;
            res.frame_end    = 1'b1;
          end else begin
            state_next.phase = PH_DATA;
          end
        end
        PH_DATA: begin
          res_en   = 1'b1;
          res.kind = KIND_DATA;
          if (cur.remaining <= 16'd1) begin
            state_next.remaining = 16'd0;
            state_next.phase     = PH_HUNT1;
            res.frame_end        = 1'b1;
          end else begin
            state_next.remaining = cur.remaining - 16'd1;
          end
        end
        default: begin
          state_next.phase = PH_HUNT1;
        end
      endcase
    end
  end

  // Output register: drop on take, load when the update stage advances with a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (wr_en && res_en) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && res_en) begin
      result <= res;
    end
  end

  // Checks
  a_stall_needs_stage: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid)
    else $error("item_stall raised with an empty update stage");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_EMPTY) |->
      (result.payload == 8'd0 && result.frame_end))
    else $error("empty frame marker with payload or without frame_end");

  a_option_no_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_OPTION) |-> !result.frame_end)
    else $error("option byte flagged as frame end");

  a_fwd_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(fwd_hit) |-> $past(wr_en))
    else $error("forwarding set without a write-back");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.kind <= KIND_EMPTY))
    else $error("result kind out of range");

endmodule
